[hw/rtl/tds_pkg.sv]
// shared constants and types for the tridiagonal solver
`default_nettype none
package tds_pkg;
	localparam int MAX_ROWS_DEF  = 64;
	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int IDX_W         = 6;
	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh80000000;

	// sequencer states, one-hot
	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_RD    = 9'b000000010,
		ST_MULA  = 9'b000000100,
		ST_MULB  = 9'b000001000,
		ST_DIV1  = 9'b000010000,
		ST_DIV2  = 9'b000100000,
		ST_BRD   = 9'b001000000,
		ST_BMUL  = 9'b010000000,
		ST_BOUT  = 9'b100000000
	} state_t;

	// saturate a 34 bit signed value to 32 bits
	function automatic logic signed [DATA_W-1:0] sat34(input logic signed [DATA_W+1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > 34'(S32_MAX))      r = S32_MAX;
		else if (v < 34'(S32_MIN)) r = S32_MIN;
		else                       r = v[DATA_W-1:0];
		return r;
	endfunction
endpackage
`default_nettype wire

[hw/rtl/tridiagonal_system_solver.sv]
// tridiagonal solver: forward sweep per row, back substitution after the last row
//  channel | dir | handshake          | fields
//  row     | in  | start & !busy      | sub_diag main_diag super_diag rhs last_row
//  result  | out | result_valid pulse | solution row_index singular last_result
// a row keeps busy high through a store read, two multiplies (skipped on row 0) and two
// divisions by the shared radix-2 divider (one quotient bit per cycle), data in Q16.16 by
// default. after the last row, each result of back substitution but the first passes a
// store read, one multiply and the output step.
// arst_n clears the sequencer, row count, singular mark and result_valid; stores need no clearing.
// results cannot be stalled by the receiver; busy is high while a row is worked on or results are sent.
`default_nettype none
module tridiagonal_system_solver
	import tds_pkg::*;
#(
	parameter int MAX_ROWS  = MAX_ROWS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	output logic                    busy,
	input  wire signed [DATA_W-1:0] sub_diag,
	input  wire signed [DATA_W-1:0] main_diag,
	input  wire signed [DATA_W-1:0] super_diag,
	input  wire signed [DATA_W-1:0] rhs,
	input  wire                     last_row,
	output logic                    result_valid,
	output logic signed [DATA_W-1:0] solution,
	output logic [IDX_W-1:0]        row_index,
	output logic                    singular,
	output logic                    last_result
);
	localparam int AW  = $clog2(MAX_ROWS);
	localparam int CW  = AW + 1;
	localparam int NW  = DATA_W + FRAC_BITS + 1;   // dividend magnitude width
	localparam int DCW = $clog2(NW + 1);

	state_t state_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q, bk_q;
	logic          pz_q, last_q, which_q;
	logic signed [DATA_W-1:0] a_q, b_q, c_q, r_q, den_q, dnum_q, x_q;
	logic signed [DATA_W-1:0] rd_ratio_q, rd_scaled_q;
	// ratio held between the two divisions of a row
	logic signed [DATA_W-1:0] rd_ratio_q_hold;

	// forward sweep stores
	logic signed [DATA_W-1:0] ratio_mem   [MAX_ROWS];
	logic signed [DATA_W-1:0] scaled_mem  [MAX_ROWS];
	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic signed [DATA_W-1:0] wr_ratio, wr_scaled;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ratio_mem[wr_addr]  <= wr_ratio;
			scaled_mem[wr_addr] <= wr_scaled;
		end
		rd_ratio_q  <= ratio_mem[rd_addr];
		rd_scaled_q <= scaled_mem[rd_addr];
	end

	// shared multiplier: floor((p*q) >> FRAC_BITS), saturated
	logic signed [DATA_W-1:0] mul_x, mul_y, mul_res;
	logic signed [2*DATA_W-1:0] prod;
	logic signed [2*DATA_W-1:0] prod_sh;
	always_comb begin
		prod    = mul_x * mul_y;
		prod_sh = prod >>> FRAC_BITS;
		if (prod_sh > 64'(S32_MAX))      mul_res = S32_MAX;
		else if (prod_sh < 64'(S32_MIN)) mul_res = S32_MIN;
		else                             mul_res = prod_sh[DATA_W-1:0];
	end

	// shared radix-2 restoring divider on magnitudes
	logic [NW-1:0]     dv_rem_q, dv_quo_q;
	logic [NW-1:0]     dv_num_q;
	logic [DATA_W-1:0] dv_den_q;
	logic [DCW-1:0]    dv_cnt_q;
	logic              dv_neg_q;
	logic [NW:0]       dv_trial;
	logic [NW-1:0]     dv_shift;
	logic signed [DATA_W-1:0] dv_res;
	logic [NW-1:0]     qmag;
	assign dv_shift = {dv_rem_q[NW-2:0], dv_num_q[NW-1]};
	assign dv_trial = {1'b0, dv_shift} - {{(NW-DATA_W+1){1'b0}}, dv_den_q};
	always_comb begin
		qmag = dv_quo_q;
		if (qmag > (NW'(1) << 32)) qmag = NW'(1) << 32;
		if (dv_neg_q) dv_res = (qmag >= NW'(64'h80000000)) ? S32_MIN : -DATA_W'(qmag);
		else          dv_res = (qmag > NW'(64'h7fffffff)) ? S32_MAX : DATA_W'(qmag);
	end

	// divider operand set-up
	function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
		return v[DATA_W-1] ? DATA_W'(-{1'b0, v}) : DATA_W'(v);
	endfunction
	logic [DATA_W:0] num_abs_w;
	logic signed [DATA_W-1:0] num_sel;
	assign num_sel   = which_q ? dnum_q : c_q;
	assign num_abs_w = num_sel[DATA_W-1] ? -{num_sel[DATA_W-1], num_sel}
	                                     : {1'b0, num_sel};

	logic last_eff;
	assign last_eff = last_row || (count_q >= CW'(MAX_ROWS - 1));

	assign busy = (state_q != ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			pz_q         <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= (state_q == ST_BOUT);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						a_q     <= sub_diag;
						b_q     <= main_diag;
						c_q     <= last_eff ? '0 : super_diag;
						r_q     <= rhs;
						last_q  <= last_eff;
						idx_q   <= AW'(count_q);
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (idx_q == '0) begin
						den_q   <= b_q;
						dnum_q  <= r_q;
						state_q <= ST_DIV1;
						which_q <= 1'b0;
						dv_cnt_q <= '0;
					end else state_q <= ST_MULA;
				end
				ST_MULA: begin
					den_q   <= sat34(34'(b_q) - 34'(mul_res));
					state_q <= ST_MULB;
				end
				ST_MULB: begin
					dnum_q   <= sat34(34'(r_q) - 34'(mul_res));
					which_q  <= 1'b0;
					dv_cnt_q <= '0;
					state_q  <= ST_DIV1;
				end
				ST_DIV1: begin
					// load divider with c or dnum over den
					dv_num_q <= NW'(num_abs_w) << FRAC_BITS;
					dv_den_q <= mag(den_q);
					dv_neg_q <= num_sel[DATA_W-1] ^ den_q[DATA_W-1];
					dv_rem_q <= '0;
					dv_quo_q <= '0;
					dv_cnt_q <= DCW'(NW);
					state_q  <= ST_DIV2;
				end
				ST_DIV2: begin
					if (dv_cnt_q != '0) begin
						dv_num_q <= dv_num_q << 1;
						if (!dv_trial[NW]) begin
							dv_rem_q <= dv_trial[NW-1:0];
							dv_quo_q <= {dv_quo_q[NW-2:0], 1'b1};
						end else begin
							dv_rem_q <= dv_shift;
							dv_quo_q <= {dv_quo_q[NW-2:0], 1'b0};
						end
						dv_cnt_q <= dv_cnt_q - DCW'(1);
					end else if (!which_q) begin
						// keep the ratio until the second quotient is ready
						rd_ratio_q_hold <= (den_q == '0) ? '0 : dv_res;
						which_q <= 1'b1;
						state_q <= ST_DIV1;
					end else begin
						if (den_q == '0) pz_q <= 1'b1;
						if (last_q) begin
							bk_q    <= idx_q;
							x_q     <= (den_q == '0) ? '0 : dv_res;
							state_q <= ST_BOUT;
						end else begin
							count_q <= count_q + CW'(1);
							state_q <= ST_IDLE;
						end
					end
				end
				ST_BRD:  state_q <= ST_BMUL;
				ST_BMUL: begin
					x_q     <= sat34(34'(rd_scaled_q) - 34'(mul_res));
					state_q <= ST_BOUT;
				end
				ST_BOUT: begin
					solution     <= pz_q ? '0 : x_q;
					row_index    <= IDX_W'(bk_q);
					singular     <= pz_q;
					last_result  <= (bk_q == '0);
					if (bk_q == '0) begin
						count_q <= '0;
						pz_q    <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						bk_q    <= bk_q - AW'(1);
						state_q <= ST_BRD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// store write on the second quotient, reads for the sweep and back substitution
	logic st_last_div;
	assign st_last_div = (state_q == ST_DIV2) && (dv_cnt_q == '0) && which_q;
	always_comb begin
		wr_en     = st_last_div;
		wr_addr   = idx_q;
		wr_ratio  = rd_ratio_q_hold;
		wr_scaled = (den_q == '0) ? '0 : dv_res;
		mul_x     = a_q;
		mul_y     = (state_q == ST_MULB) ? rd_scaled_q : rd_ratio_q;
		if (state_q == ST_BMUL) begin
			mul_x = rd_ratio_q;
			mul_y = x_q;
		end
		if (state_q == ST_IDLE)
			rd_addr = (count_q == '0) ? '0 : AW'(count_q - CW'(1));
		else if (state_q == ST_RD || state_q == ST_MULA)
			rd_addr = idx_q - AW'(1);
		else
			rd_addr = bk_q;
	end
endmodule
`default_nettype wire

[hw/rtl/tds_checker.sv]
// port-level checks for the tridiagonal solver
`default_nettype none
module tds_checker
	import tds_pkg::*;
(
	input wire              clk,
	input wire              arst_n,
	input wire              start,
	input wire              busy,
	input wire              result_valid,
	input wire [DATA_W-1:0] solution,
	input wire [IDX_W-1:0]  row_index,
	input wire              singular,
	input wire              last_result
);
	// an accepted row makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted row without busy");
	// a singular system reports zero solutions
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && singular |-> solution == '0) else $error("singular nonzero");
	// last result carries row zero
	a_last_row0: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_result |-> row_index == '0) else $error("last not row 0");
	// results only follow a busy cycle
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy)) else $error("result while idle");
	// row indices fall by one
	a_desc: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_result |=> ##2 result_valid && row_index == $past(row_index, 3) - 1'b1)
		else $error("index order");
endmodule

bind tridiagonal_system_solver tds_checker u_tds_checker (.*);
`default_nettype wire
